// ----- rtl/lfu_pkg.sv -----
package lfu_pkg;

  localparam int PAGE_W         = 8;
  localparam int COUNT_W        = 16;
  localparam int FAULT_W        = 32;
  localparam int NFR_W          = 4;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int NUM_PAGES_DEF  = 256;

  localparam logic [NFR_W-1:0] NUM_FRAMES_RESET = NFR_W'(8);

  // register indexes
  localparam logic REG_NUM_FRAMES = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_BUMPRD,
    S_UPDATE
  } lfu_state_t;

  typedef struct packed {
    logic clear_en;
    logic start;
    logic scan_en;
    logic bump_rd;
    logic commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic filled_zero;
    logic scan_last;
  } lfu_status_t;

endpackage

// ----- rtl/lfu_ctrl.sv -----
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lfu_pkg::lfu_status_t status,
  output lfu_pkg::lfu_cmd_t    cmd
);

  lfu_pkg::lfu_state_t state, state_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfu_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lfu_pkg::S_CLEAR: begin
        if (status.clr_last) state_next = lfu_pkg::S_IDLE;
      end
      lfu_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = status.filled_zero ? lfu_pkg::S_BUMPRD : lfu_pkg::S_SCAN;
        end
      end
      lfu_pkg::S_SCAN: begin
        if (status.scan_last) state_next = lfu_pkg::S_BUMPRD;
      end
      lfu_pkg::S_BUMPRD: state_next = lfu_pkg::S_UPDATE;
      lfu_pkg::S_UPDATE: begin
        if (out_free) state_next = lfu_pkg::S_IDLE;
      end
      default: state_next = lfu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      lfu_pkg::S_CLEAR:  cmd.clear_en = 1'b1;
      lfu_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      lfu_pkg::S_SCAN:   cmd.scan_en = 1'b1;
      lfu_pkg::S_BUMPRD: cmd.bump_rd = 1'b1;
      lfu_pkg::S_UPDATE: cmd.commit  = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/lfu_dp.sv -----
module lfu_dp #(
  parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES_DEF,
  parameter int NUM_PAGES  = lfu_pkg::NUM_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lfu_pkg::lfu_cmd_t            cmd,
  output lfu_pkg::lfu_status_t         status,
  input  logic [lfu_pkg::PAGE_W-1:0]   page,
  input  logic [lfu_pkg::NFR_W-1:0]    num_frames,
  output logic                         hit,
  output logic                         evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0]  fault_count
);

  localparam int PW      = lfu_pkg::PAGE_W;
  localparam int CW      = lfu_pkg::COUNT_W;
  localparam int FTW     = lfu_pkg::FAULT_W;
  localparam int SLOTW   = $clog2(NUM_PAGES);
  localparam int IDXW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW      = $clog2(MAX_FRAMES + 1);
  localparam int LW      = (FW > lfu_pkg::NFR_W) ? FW : lfu_pkg::NFR_W;
  localparam int NPG     = 2 ** PW;

  // page number to count slot, page modulo NUM_PAGES
  logic [SLOTW-1:0] slot_tab [NPG];
  for (genvar g = 0; g < NPG; g++) begin : g_slot
    localparam int unsigned SLOT_VAL = g % NUM_PAGES;
    assign slot_tab[g] = SLOTW'(SLOT_VAL);
  end

  logic [PW-1:0]    frames [MAX_FRAMES];
  logic [FW-1:0]    filled;
  logic [PW-1:0]    page_r;
  logic [IDXW-1:0]  idx;
  logic             found;
  logic [CW-1:0]    best;
  logic             best_vld;
  logic [IDXW-1:0]  victim;
  logic [PW-1:0]    victim_page;
  logic             rd_vld;
  logic [IDXW-1:0]  rd_idx;
  logic [PW-1:0]    rd_page;
  logic [CW-1:0]    cnt_q;
  logic [SLOTW-1:0] clr_addr;
  logic [FTW-1:0]   fault_total;

  logic [CW-1:0]    cnt_mem [NUM_PAGES];

  logic [PW-1:0]    frame_rd;
  logic [SLOTW-1:0] rd_addr;
  logic             rd_en;
  logic             mem_we;
  logic [SLOTW-1:0] wr_addr;
  logic [CW-1:0]    wr_data;
  logic [CW-1:0]    cnt_inc;
  logic [LW-1:0]    nf_ext;
  logic [LW-1:0]    limit;
  logic             room;
  logic             miss;
  logic             evict;
  logic [FTW-1:0]   fault_inc;

  assign frame_rd = frames[idx];

  always_comb begin
    nf_ext = LW'(num_frames);
    if (nf_ext == '0) begin
      limit = LW'(1);
    end else if (nf_ext > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = nf_ext;
    end
  end

  assign room      = LW'(filled) < limit;
  assign miss      = !found;
  assign evict     = miss && !room;
  assign cnt_inc   = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + CW'(1);
  assign fault_inc = (fault_total == {FTW{1'b1}}) ? fault_total : fault_total + FTW'(1);

  assign rd_en   = cmd.scan_en || cmd.bump_rd;
  assign rd_addr = cmd.bump_rd ? slot_tab[page_r] : slot_tab[frame_rd];
  assign mem_we  = cmd.clear_en || cmd.commit;
  assign wr_addr = cmd.clear_en ? clr_addr : slot_tab[page_r];
  assign wr_data = cmd.clear_en ? '0 : cnt_inc;

  assign status.clr_last    = clr_addr == SLOTW'(NUM_PAGES - 1);
  assign status.filled_zero = filled == '0;
  assign status.scan_last   = (FW'(idx) + FW'(1)) == filled;

  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[wr_addr] <= wr_data;
    if (rd_en) cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + SLOTW'(1);
    end
  end

  // scan: issue count reads in list order, compare each count in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r   <= page;
      idx      <= '0;
      found    <= 1'b0;
      best_vld <= 1'b0;
      victim   <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_en;
      if (cmd.scan_en) begin
        rd_idx  <= idx;
        rd_page <= frame_rd;
        idx     <= idx + IDXW'(1);
        if (frame_rd == page_r) found <= 1'b1;
      end
      // strict less-than keeps the earliest frame on a tie
      if (rd_vld && (!best_vld || cnt_q < best)) begin
        best        <= cnt_q;
        best_vld    <= 1'b1;
        victim      <= rd_idx;
        victim_page <= rd_page;
      end
    end
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_frame
    always_ff @(posedge clk) begin
      if (cmd.commit && miss) begin
        if (room) begin
          if (FW'(g) == filled) frames[g] <= page_r;
        end else if (FW'(g) == filled - FW'(1)) begin
          frames[g] <= page_r;
        end else if (FW'(g) >= FW'(victim)) begin
          if (g < MAX_FRAMES - 1) frames[g] <= frames[(g < MAX_FRAMES - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled        <= '0;
      fault_total   <= '0;
      hit           <= 1'b0;
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      fault_count   <= '0;
    end else if (cmd.commit) begin
      if (miss) begin
        fault_total <= fault_inc;
        fault_count <= fault_inc;
        if (room) filled <= filled + FW'(1);
      end else begin
        fault_count <= fault_total;
      end
      hit           <= found;
      evicted_valid <= evict;
      evicted_page  <= evict ? victim_page : '0;
    end
  end

endmodule

// ----- rtl/lfu_page_replacement.sv -----
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   page
// result    out        out_valid / out_ready hit, evicted_valid, evicted_page, fault_count
// config    in         APB psel/penable      paddr, pwdata, prdata (num_frames at 0x0)
//
// A request is accepted, then the resident frames are scanned in list order for the
// hit and the least count through the count memory's single read port, then the
// referenced page's count is read and written back. After reset a clearing pass
// zeroes all NUM_PAGES count slots (256 by default), during which no request is
// taken; configuration writes still land.
// The result waits in an output register; the next request is accepted meanwhile and
// only its write-back waits while an earlier result is still untaken.
module lfu_page_replacement #(
  parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES_DEF,
  parameter int NUM_PAGES  = lfu_pkg::NUM_PAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lfu_pkg::PAGE_W-1:0]       page,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic                             evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]       evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0]      fault_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfu_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lfu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  lfu_pkg::lfu_cmd_t               cmd;
  lfu_pkg::lfu_status_t            status;
  logic [lfu_pkg::NFR_W-1:0]       num_frames;
  logic                            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == lfu_pkg::REG_NUM_FRAMES;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= lfu_pkg::NUM_FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      num_frames <= pwdata[lfu_pkg::NFR_W-1:0];
    end
  end

  assign prdata = reg_sel ? lfu_pkg::APB_DATA_W'(num_frames) : '0;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfu_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .NUM_PAGES  (NUM_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .page          (page),
    .num_frames    (num_frames),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

endmodule

// ----- rtl/lfu_checker.sv -----
module lfu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        hit,
  input logic                        evicted_valid,
  input logic [lfu_pkg::PAGE_W-1:0]  evicted_page,
  input logic [lfu_pkg::FAULT_W-1:0] fault_count
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page not zero without eviction");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> fault_count != '0)
    else $error("fault reported but fault count is zero");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fault_count >= $past(fault_count))
    else $error("fault count went backwards");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (.*);

// ----- tb/sv/lfu_page_replacement_test.sv -----
`timescale 1ns / 1ps

module lfu_page_replacement_test;
  import lfu_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOT_REPS     = 30;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES  = 24;
  localparam int PRINT_LIMIT  = 40;
  localparam int REG_SPARE    = 1;   // first index with no register behind it
  localparam int NUM_ROWS     = 21;

  localparam logic [APB_ADDR_W-1:0] NF_ADDR    = APB_ADDR_W'(4 * int'(REG_NUM_FRAMES));
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * REG_SPARE);

  typedef struct packed {
    logic                 page_hit;
    logic                 evicted;
    logic [PAGE_W-1:0]    victim_page;
    logic [FAULT_W-1:0]   faults;
  } outcome_t;

  typedef struct {
    bit                       is_cfg;
    logic [APB_ADDR_W-1:0]    addr;
    logic [APB_DATA_W-1:0]    wdata;
    logic [PAGE_W-1:0]        pg;
    int                       reps;
    bit                       typed;
    outcome_t                 want;
  } step_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PAGE_W-1:0]       page = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit;
  logic                    evicted_valid;
  logic [PAGE_W-1:0]       evicted_page;
  logic [FAULT_W-1:0]      fault_count;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // mirror of the block's state
  logic [PAGE_W-1:0]   resident [MAX_FRAMES_DEF];
  int                  occupancy;
  logic [COUNT_W-1:0]  use_count [NUM_PAGES_DEF];
  logic [FAULT_W-1:0]  fault_total;
  logic [NFR_W-1:0]    frames_reg;

  outcome_t  pending_outcomes [$];
  step_row_t directed_rows [NUM_ROWS];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  lfu_page_replacement u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h (cycle %0d)",
               what, want, got, cycle_count);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void bump_use(input logic [PAGE_W-1:0] pg);
    if (use_count[pg] != '1)
      use_count[pg] = use_count[pg] + 1'b1;
  endfunction

  // one reference through the LFU list: hit lookup, append or evict, counters
  function automatic outcome_t replace_page(input logic [PAGE_W-1:0] pg);
    outcome_t           res;
    int                 limit;
    int                 victim;
    logic [COUNT_W-1:0] least;
    res = '0;
    for (int i = 0; i < occupancy; i++)
      if (resident[i] == pg) res.page_hit = 1'b1;
    if (res.page_hit) begin
      bump_use(pg);
    end else begin
      limit = (frames_reg == 0) ? 1 : int'(frames_reg);
      if (limit > MAX_FRAMES_DEF) limit = MAX_FRAMES_DEF;
      if (occupancy < limit) begin
        resident[occupancy] = pg;
        occupancy++;
      end else begin
        // occupancy may exceed the limit after it was lowered; scan them all
        victim = 0;
        least = use_count[resident[0]];
        for (int i = 1; i < occupancy; i++) begin
          if (use_count[resident[i]] < least) begin
            least = use_count[resident[i]];
            victim = i;
          end
        end
        res.evicted = 1'b1;
        res.victim_page = resident[victim];
        for (int i = victim; i + 1 < occupancy; i++)
          resident[i] = resident[i + 1];
        resident[occupancy - 1] = pg;
      end
      bump_use(pg);
      if (fault_total != '1) fault_total = fault_total + 1'b1;
    end
    res.faults = fault_total;
    return res;
  endfunction

  // result side: random back-pressure, compare against the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'd0, 32'd1);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.page_hit)
          report_mismatch("hit", 32'(want.page_hit), 32'(hit));
        if (evicted_valid !== want.evicted)
          report_mismatch("evicted_valid", 32'(want.evicted), 32'(evicted_valid));
        if (evicted_page !== want.victim_page)
          report_mismatch("evicted_page", 32'(want.victim_page), 32'(evicted_page));
        if (fault_count !== want.faults)
          report_mismatch("fault_count", want.faults, fault_count);
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_request(input logic [PAGE_W-1:0] pg, input bit typed,
                              input outcome_t typed_want);
    outcome_t predicted;
    outcome_t queued;
    int       gap;
    in_valid <= 1'b1;
    page <= pg;
    do @(posedge clk); while (!in_ready);
    predicted = replace_page(pg);
    queued = typed ? typed_want : predicted;
    pending_outcomes = {pending_outcomes, queued};
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic check_frames_readback();
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, NF_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(frames_reg))
      report_mismatch("num_frames readback", APB_DATA_W'(frames_reg), rd);
  endtask

  // only with nothing in flight: drain every outstanding result first
  task automatic apply_config(input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] rd;
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    apb_access(1'b1, addr, data, rd);
    if (addr == NF_ADDR) frames_reg = data[NFR_W-1:0];
    check_frames_readback();
  endtask

  function automatic step_row_t cfg_row(input logic [APB_ADDR_W-1:0] a,
                                        input logic [APB_DATA_W-1:0] d);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.addr = a;
    r.wdata = d;
    r.pg = '0;
    r.reps = 0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic step_row_t typed_row(input logic [PAGE_W-1:0] pg, input int reps,
                                          input logic h, input logic ev,
                                          input logic [PAGE_W-1:0] evp,
                                          input logic [FAULT_W-1:0] f);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.addr = '0;
    r.wdata = '0;
    r.pg = pg;
    r.reps = reps;
    r.typed = 1'b1;
    r.want = '{page_hit: h, evicted: ev, victim_page: evp, faults: f};
    return r;
  endfunction

  function automatic step_row_t item_row(input logic [PAGE_W-1:0] pg);
    step_row_t r;
    r = typed_row(pg, 1, 1'b0, 1'b0, '0, '0);
    r.typed = 1'b0;
    return r;
  endfunction

  initial begin
    logic [PAGE_W-1:0]     pool [16];
    logic [PAGE_W-1:0]     pg;
    logic [NFR_W-1:0]      frames_pick;
    logic [APB_DATA_W-1:0] wdata;
    int                    phase;
    int                    sent;
    int                    len;
    int                    pool_size;

    foreach (use_count[i]) use_count[i] = '0;
    foreach (resident[i]) resident[i] = '0;
    occupancy = 0;
    fault_total = '0;
    frames_reg = NUM_FRAMES_RESET;

    directed_rows = '{
      cfg_row(NF_ADDR, 32'd0),                          // zero frames acts as one
      typed_row(8'h00, 1, 1'b0, 1'b0, 8'h00, 32'd1),
      typed_row(8'hFF, 1, 1'b0, 1'b1, 8'h00, 32'd2),
      typed_row(8'hFF, HOT_REPS, 1'b1, 1'b0, 8'h00, 32'd2), // makes this page heavily used
      cfg_row(NF_ADDR, 32'd2),
      typed_row(8'h12, 1, 1'b0, 1'b0, 8'h00, 32'd3),
      typed_row(8'h34, 1, 1'b0, 1'b1, 8'h12, 32'd4),    // heavily used page survives
      cfg_row(NF_ADDR, 32'hFFFF_FFFF),                  // 15 clips to the frame maximum
      item_row(8'h01), item_row(8'h02), item_row(8'h04),
      item_row(8'h08), item_row(8'h10), item_row(8'h20),
      typed_row(8'h40, 1, 1'b0, 1'b1, 8'h34, 32'd11),
      cfg_row(SPARE_ADDR, 32'd1),                       // no register there, ignored
      item_row(8'h80),
      cfg_row(NF_ADDR, 32'd1),                          // limit now below occupancy
      item_row(8'h00), item_row(8'h00), item_row(8'hFF)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_frames_readback();

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        apply_config(directed_rows[r].addr, directed_rows[r].wdata);
      end else begin
        quiet = (directed_rows[r].reps > 1);
        repeat (directed_rows[r].reps)
          send_request(directed_rows[r].pg, directed_rows[r].typed, directed_rows[r].want);
        quiet = 1'b0;
      end
    end

    // random phases: a small working set per phase so hits and evictions both occur
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       frames_pick = 4'd8;
        1:       frames_pick = 4'd1;
        2:       frames_pick = 4'd15;
        3:       frames_pick = 4'd0;
        default: frames_pick = NFR_W'($urandom_range(0, 15));
      endcase
      wdata = $urandom();
      wdata[NFR_W-1:0] = frames_pick;
      quiet = 1'b0;
      apply_config(NF_ADDR, wdata);
      quiet = (phase % 4 == 3);
      pool_size = $urandom_range(2, 14);
      foreach (pool[i]) pool[i] = PAGE_W'($urandom());
      len = $urandom_range(40, 160);
      repeat (len) begin
        if ($urandom_range(0, 19) == 0)
          pool[$urandom_range(0, pool_size - 1)] = PAGE_W'($urandom());
        if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom());
        else pg = pool[$urandom_range(0, pool_size - 1)];
        send_request(pg, 1'b0, '0);
      end
      sent += len;
      phase++;
    end

    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- lfu_page_replacement.f -----
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_page_replacement.sv
rtl/lfu_checker.sv
tb/sv/lfu_page_replacement_test.sv
